/* design/rdiv96_pkg.sv */
// Shared types and constants for the restoring divider.
`default_nettype none
package rdiv96_pkg;

	localparam int OPERAND_BITS_DEF = 96;
	localparam int CELL_BITS        = 8;
	localparam int LOW_W            = 64;
	localparam int HIGH_W           = 32;
	localparam int EXT_W            = 2 * LOW_W;

	typedef struct packed {
		logic [LOW_W-1:0]  dividend_low;
		logic [HIGH_W-1:0] dividend_high;
		logic [LOW_W-1:0]  divisor_low;
		logic [HIGH_W-1:0] divisor_high;
	} rdiv96_op_t;

	typedef struct packed {
		logic [LOW_W-1:0]  quotient_low;
		logic [HIGH_W-1:0] quotient_high;
		logic [LOW_W-1:0]  remainder_low;
		logic [HIGH_W-1:0] remainder_high;
		logic              divide_by_zero;
	} rdiv96_res_t;

	// bits handed from one cell to the next higher one
	typedef struct packed {
		logic rem_bit;
		logic quo_bit;
		logic borrow;
	} rdiv96_link_t;

	// broadcast to every cell
	typedef struct packed {
		logic load;
		logic step;
		logic ge;
	} rdiv96_ctrl_t;

endpackage
`default_nettype wire

/* design/rdiv96_cell.sv */
// One slice of the partial remainder, quotient and divisor with its subtractor.
`default_nettype none
module rdiv96_cell (
	input  wire logic                              clk,
	input  wire rdiv96_pkg::rdiv96_ctrl_t          ctrl,
	input  wire logic [rdiv96_pkg::CELL_BITS-1:0]  ld_quo,
	input  wire logic [rdiv96_pkg::CELL_BITS-1:0]  ld_dvs,
	input  wire rdiv96_pkg::rdiv96_link_t          link_in,
	output rdiv96_pkg::rdiv96_link_t               link_out,
	output logic [rdiv96_pkg::CELL_BITS-1:0]       rem,
	output logic [rdiv96_pkg::CELL_BITS-1:0]       quo
);
	import rdiv96_pkg::*;

	logic [CELL_BITS-1:0] rem_q;
	logic [CELL_BITS-1:0] quo_q;
	logic [CELL_BITS-1:0] dvs_q;
	logic [CELL_BITS-1:0] shifted;
	logic [CELL_BITS:0]   diff;

	assign shifted = {rem_q[CELL_BITS-2:0], link_in.rem_bit};
	assign diff    = {1'b0, shifted} - {1'b0, dvs_q} - {{CELL_BITS{1'b0}}, link_in.borrow};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= '0;
			quo_q <= ld_quo;
			dvs_q <= ld_dvs;
		end else if (ctrl.step) begin
			rem_q <= ctrl.ge ? diff[CELL_BITS-1:0] : shifted;
			quo_q <= {quo_q[CELL_BITS-2:0], link_in.quo_bit};
		end
	end

	assign link_out.rem_bit = rem_q[CELL_BITS-1];
	assign link_out.quo_bit = quo_q[CELL_BITS-1];
	assign link_out.borrow  = diff[CELL_BITS];
	assign rem = rem_q;
	assign quo = quo_q;

endmodule
`default_nettype wire

/* design/restoring_divider_96bit.sv */
// Top level: unsigned restoring divider built from a chain of remainder cells.
//
// Operand channel (op_valid/op_ready/op) takes dividend and divisor; result
// channel (res_valid/res_ready/res) returns quotient, remainder and the
// divide_by_zero flag. One item is in the datapath at a time.
// Sequence: the transfer edge loads the cells, then OPERAND_BITS shift-subtract
// steps follow (one quotient bit per cycle, set by the carry chain through
// the cells), then the output register is written. res_valid and op_ready
// rise together on that write, so the next operand is taken only after the
// last item has left the cells for the output register.
// The output register is separate from the cells: a new operand is taken
// while a result waits. If the receiver stalls and the output register is
// still full when the next item finishes, that item holds in the cells
// until res_ready frees the register.
// Reset clears the control state and the output valid; op_ready is high
// after reset.
`default_nettype none
module restoring_divider_96bit #(
	parameter int OPERAND_BITS = rdiv96_pkg::OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    op_valid,
	output logic                         op_ready,
	input  wire rdiv96_pkg::rdiv96_op_t  op,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output rdiv96_pkg::rdiv96_res_t      res
);
	import rdiv96_pkg::*;

	localparam int NCELL = (OPERAND_BITS + CELL_BITS) / CELL_BITS;
	localparam int W     = NCELL * CELL_BITS;
	localparam int SH    = W - OPERAND_BITS;
	localparam int CNT_W = $clog2(OPERAND_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    seen_q;
	logic                    dz_q;
	logic                    res_valid_q;
	rdiv96_res_t             res_q;

	logic [EXT_W-1:0]        dvd_ext;
	logic [EXT_W-1:0]        dvs_ext;
	logic [OPERAND_BITS-1:0] dvd_op;
	logic [OPERAND_BITS-1:0] dvs_op;
	logic [W-1:0]            ld_quo_all;
	logic [W-1:0]            ld_dvs_all;
	logic [W-1:0]            rem_all;
	logic [W-1:0]            quo_all;
	logic [EXT_W-1:0]        quo_ext;
	logic [EXT_W-1:0]        rem_ext;
	rdiv96_link_t            link [NCELL+1];
	rdiv96_ctrl_t            ctrl;
	logic                    accept;
	logic                    seen_now;
	logic                    capture;

	assign accept   = op_valid && op_ready;
	assign op_ready = (state_q == ST_IDLE);
	assign capture  = (state_q == ST_FIN) && (!res_valid_q || res_ready);

	assign dvd_ext    = EXT_W'({op.dividend_high, op.dividend_low});
	assign dvs_ext    = EXT_W'({op.divisor_high, op.divisor_low});
	assign dvd_op     = dvd_ext[OPERAND_BITS-1:0];
	assign dvs_op     = dvs_ext[OPERAND_BITS-1:0];
	assign ld_quo_all = W'(dvd_op) << SH;
	assign ld_dvs_all = W'(dvs_op);

	// quotient bits above the dividend's leading one stay zero
	assign seen_now = seen_q || link[0].rem_bit;

	assign ctrl.load = accept;
	assign ctrl.step = (state_q == ST_RUN);
	assign ctrl.ge   = !link[NCELL].borrow;

	assign link[0].rem_bit = link[NCELL].quo_bit;
	assign link[0].quo_bit = ctrl.ge && seen_now;
	assign link[0].borrow  = 1'b0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rdiv96_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.ld_quo   (ld_quo_all[i*CELL_BITS +: CELL_BITS]),
			.ld_dvs   (ld_dvs_all[i*CELL_BITS +: CELL_BITS]),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.rem      (rem_all[i*CELL_BITS +: CELL_BITS]),
			.quo      (quo_all[i*CELL_BITS +: CELL_BITS])
		);
	end

	assign quo_ext = EXT_W'(quo_all[OPERAND_BITS-1:0]);
	assign rem_ext = EXT_W'(rem_all[OPERAND_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			seen_q      <= 1'b0;
			dz_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(OPERAND_BITS - 1);
						seen_q  <= 1'b0;
						dz_q    <= (dvs_op == '0);
					end
				end
				ST_RUN: begin
					seen_q <= seen_now;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (capture) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (capture) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			res_q.quotient_low   <= quo_ext[LOW_W-1:0];
			res_q.quotient_high  <= quo_ext[LOW_W +: HIGH_W];
			res_q.remainder_low  <= rem_ext[LOW_W-1:0];
			res_q.remainder_high <= rem_ext[LOW_W +: HIGH_W];
			res_q.divide_by_zero <= dz_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

/* design/rdiv96_chk.sv */
// Port-level checks for the restoring divider, bound to the top level.
`default_nettype none
module rdiv96_chk (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    op_valid,
	input wire logic                    op_ready,
	input wire logic                    res_valid,
	input wire logic                    res_ready,
	input wire rdiv96_pkg::rdiv96_res_t res
);
	import rdiv96_pkg::*;

	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> !op_ready)
		else $error("op_ready high right after an operand transfer");

	a_busy_two: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |-> ##2 !op_ready)
		else $error("divider idle too soon after an operand transfer");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result dropped or changed");

	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> op_ready)
		else $error("new result while divider still busy");

	a_zero_dividend: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_by_zero && res.quotient_low == '0 && res.quotient_high == '0
		|-> res.remainder_low == '0 && res.remainder_high == '0)
		else $error("zero divisor with zero quotient but nonzero remainder");

endmodule

bind restoring_divider_96bit rdiv96_chk u_rdiv96_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (op_valid),
	.op_ready  (op_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
